### hw/rtl/plc_pkg.sv
package plc_pkg;

   localparam int DEFAULT_DEPTH      = 64;
   localparam int DEFAULT_VALUE_BITS = 32;

   localparam int FUNC_W   = 3;
   localparam int POS_W    = 7;
   localparam int ITEM_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 48;

   localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd2;
   localparam logic [FUNC_W-1:0] FN_REM_FRONT = 3'd3;
   localparam logic [FUNC_W-1:0] FN_REM_BACK  = 3'd4;
   localparam logic [FUNC_W-1:0] FN_REM_AT    = 3'd5;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic insert;
      logic remove;
   } cell_cmd_type;

endpackage

### hw/rtl/plc_cell.sv
module plc_cell #(
   parameter int VALUE_BITS = 32,
   parameter int IDX_W      = 6,
   parameter int INDEX      = 0
) (
   input  logic                    clock,
   input  plc_pkg::cell_cmd_type   cmd,
   input  logic [IDX_W-1:0]        pos,
   input  logic [VALUE_BITS-1:0]   new_value,
   input  logic [VALUE_BITS-1:0]   left_value,
   input  logic [VALUE_BITS-1:0]   right_value,
   output logic [VALUE_BITS-1:0]   value
);
   import plc_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [VALUE_BITS-1:0] value_ff;
   logic [VALUE_BITS-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      priority if (cmd.insert) begin
         if (MY_IDX > pos) begin
            value_in = left_value;
         end else if (MY_IDX == pos) begin
            value_in = new_value;
         end
      end else if (cmd.remove) begin
         if (MY_IDX >= pos) begin
            value_in = right_value;
         end
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

### hw/rtl/positional_list_engine.sv
// Positional list engine: an ordered list of up to DEPTH values kept in a row
// of cells, one entry per cell, with position 0 in the first cell.
// Requests arrive on the req_ stream: req_tuser carries the operation code
// and req_tdata carries the position and the value to insert. Inserts and
// removes at the front, the back or a given position move every later entry
// by one cell in the same clock, since each cell loads from its neighbor.
// Every request gives exactly one word on the rsp_ stream with the removed
// value, its valid flag, a status and the entry count after the request.
// A request is decoded, applied to the cells and its response registered in
// the cycle it is accepted, so the response is valid in the next cycle.
// Throughput is one request per cycle, set by the single response register.
// When the receiver stalls, the response register holds its word and
// req_tready drops until that word is taken.
// Reset empties the list and clears the response valid; the cell contents
// are not cleared and are never read before being written.
module positional_list_engine #(
   parameter int DEPTH      = plc_pkg::DEFAULT_DEPTH,
   parameter int VALUE_BITS = plc_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // position [6:0], item_value [38:7], zero [39]
   input  logic [plc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // func [2:0]
   input  logic [plc_pkg::FUNC_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // removed_value [31:0], removed_valid [32], status [34:33],
   // entry_count [41:35], zero [47:42]
   output logic [plc_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import plc_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0]      total_ff;
   logic [CNT_W-1:0]      total_in;
   logic                  rsp_valid_ff;
   logic [ITEM_W-1:0]     removed_value_ff;
   logic [ITEM_W-1:0]     removed_value_in;
   logic                  removed_valid_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic [STATUS_W-1:0]   status_in;
   logic [COUNT_W-1:0]    count_ff;

   logic                  accept;
   logic                  is_ins;
   logic                  is_rem;
   logic [CMP_W-1:0]      total_cmp;
   logic [CMP_W-1:0]      pos_cmp;
   logic [CMP_W-1:0]      target;
   logic [IDX_W-1:0]      target_idx;
   logic                  ins_range;
   logic                  list_full;
   logic                  rem_range;
   logic                  ins_ok;
   logic                  rem_ok;
   logic [VALUE_BITS-1:0] new_value;
   cell_cmd_type          cmd;
   logic [VALUE_BITS-1:0] cell_value [DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign total_cmp  = CMP_W'(total_ff);
   assign pos_cmp    = CMP_W'(req_tdata[POS_W-1:0]);
   assign new_value  = VALUE_BITS'(req_tdata[POS_W+ITEM_W-1:POS_W]);

   always_comb begin
      is_ins = 1'b0;
      is_rem = 1'b0;
      target = '0;
      unique case (req_tuser)
         FN_INS_FRONT: begin
            is_ins = 1'b1;
         end
         FN_INS_BACK: begin
            is_ins = 1'b1;
            target = total_cmp;
         end
         FN_INS_AT: begin
            is_ins = 1'b1;
            target = pos_cmp;
         end
         FN_REM_FRONT: begin
            is_rem = 1'b1;
         end
         FN_REM_BACK: begin
            is_rem = 1'b1;
            if (total_ff != '0) begin
               target = total_cmp - CMP_W'(1);
            end
         end
         FN_REM_AT: begin
            is_rem = 1'b1;
            target = pos_cmp;
         end
         default: begin
            is_ins = 1'b0;
         end
      endcase
   end

   assign target_idx = target[IDX_W-1:0];
   assign ins_range  = target > total_cmp;
   assign list_full  = total_cmp == CMP_W'(DEPTH);
   assign rem_range  = target >= total_cmp;
   assign ins_ok     = is_ins && !ins_range && !list_full;
   assign rem_ok     = is_rem && !rem_range;

   assign cmd.insert = accept && ins_ok;
   assign cmd.remove = accept && rem_ok;

   always_comb begin
      priority if (is_ins) begin
         status_in = ins_range ? ST_RANGE : (list_full ? ST_FULL : ST_DONE);
      end else if (is_rem) begin
         status_in = rem_range ? ST_RANGE : ST_DONE;
      end else begin
         status_in = ST_RANGE;
      end
   end

   always_comb begin
      total_in = total_ff;
      if (cmd.insert) begin
         total_in = total_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         total_in = total_ff - CNT_W'(1);
      end
   end

   assign removed_value_in = rem_ok ? ITEM_W'(cell_value[target_idx]) : '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [VALUE_BITS-1:0] left_value;
      logic [VALUE_BITS-1:0] right_value;

      if (g == 0) begin : g_first
         assign left_value = new_value;
      end else begin : g_mid
         assign left_value = cell_value[g-1];
      end

      if (g == DEPTH - 1) begin : g_last
         assign right_value = cell_value[g];
      end else begin : g_inner
         assign right_value = cell_value[g+1];
      end

      plc_cell #(
         .VALUE_BITS (VALUE_BITS),
         .IDX_W      (IDX_W),
         .INDEX      (g)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .pos         (target_idx),
         .new_value   (new_value),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff <= total_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         removed_value_ff <= removed_value_in;
         removed_valid_ff <= rem_ok;
         status_ff        <= status_in;
         count_ff         <= COUNT_W'(total_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - ITEM_W - 1 - STATUS_W - COUNT_W){1'b0}},
                        count_ff, status_ff, removed_valid_ff, removed_value_ff};

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(total_ff) <= CMP_W'(DEPTH))
      else $error("List count exceeds depth.");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> total_ff == $past(total_ff) + CNT_W'(1))
      else $error("Insert did not raise the count by one.");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      cmd.remove |=> total_ff == $past(total_ff) - CNT_W'(1))
      else $error("Remove did not lower the count by one.");

   a_valid_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && removed_valid_ff |-> status_ff == ST_DONE)
      else $error("Removed word flagged valid without done status.");

   a_count_match: assert property (@(posedge clock) disable iff (reset)
      accept |=> count_ff == COUNT_W'(total_ff))
      else $error("Response count differs from list count.");

endmodule

### dv/tb_positional_list_engine.sv
`timescale 1ns / 1ps

module tb_positional_list_engine;
   import plc_pkg::*;

   localparam int LIST_DEPTH   = DEFAULT_DEPTH;
   localparam int CLOCK_PERIOD = 8;
   localparam int RESET_CYCLES = 8;
   localparam int DRAIN_CYCLES = 8;
   localparam int LIMIT_CYCLES = 400000;
   localparam int PHASE_ITEMS  = 285;

   // Operation codes that the block does not define.
   localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd6;
   localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd7;

   typedef struct packed {
      logic [ITEM_W-1:0]   removed_value;
      logic                removed_valid;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entry_count;
   } list_result_type;

   class list_scoreboard;
      logic [ITEM_W-1:0] cell_value[LIST_DEPTH];
      int                fill;
      int                errors;
      list_result_type   expected_results[$];

      function new();
         fill = 0;
         errors = 0;
      endfunction

      function logic [STATUS_W-1:0] insert_entry(int where, logic [ITEM_W-1:0] value);
         int i;
         if (where > fill) return ST_RANGE;
         if (fill >= LIST_DEPTH) return ST_FULL;
         for (i = fill; i > where; i--) cell_value[i] = cell_value[i-1];
         cell_value[where] = value;
         fill++;
         return ST_DONE;
      endfunction

      function logic [STATUS_W-1:0] take_entry(int where, output logic [ITEM_W-1:0] value,
                                               output logic valid);
         int i;
         value = '0;
         valid = 1'b0;
         if (where >= fill) return ST_RANGE;
         value = cell_value[where];
         valid = 1'b1;
         for (i = where; i + 1 < fill; i++) cell_value[i] = cell_value[i+1];
         fill--;
         return ST_DONE;
      endfunction

      function void note_request(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                                 logic [ITEM_W-1:0] value);
         list_result_type r;
         r = '0;
         case (func)
            FN_INS_FRONT: r.status = insert_entry(0, value);
            FN_INS_BACK:  r.status = insert_entry(fill, value);
            FN_INS_AT:    r.status = insert_entry(int'(pos), value);
            FN_REM_FRONT: r.status = take_entry(0, r.removed_value, r.removed_valid);
            FN_REM_BACK: begin
               if (fill == 0) r.status = ST_RANGE;
               else r.status = take_entry(fill - 1, r.removed_value, r.removed_valid);
            end
            FN_REM_AT:    r.status = take_entry(int'(pos), r.removed_value, r.removed_valid);
            default:      r.status = ST_RANGE;
         endcase
         r.entry_count = fill[COUNT_W-1:0];
         expected_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [ITEM_W-1:0] want, logic [ITEM_W-1:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] word);
         list_result_type want;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected word, expected none, actual %h", $time, word);
            return;
         end
         want = expected_results.pop_front();
         compare_field("removed_value", want.removed_value, word[31:0]);
         compare_field("removed_valid", ITEM_W'(want.removed_valid), ITEM_W'(word[32]));
         compare_field("status", ITEM_W'(want.status), ITEM_W'(word[34:33]));
         compare_field("entry_count", ITEM_W'(want.entry_count), ITEM_W'(word[41:35]));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [FUNC_W-1:0]      req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int             sender_idle_pct = 0;
   int             receiver_stall_pct = 0;
   int             cycle_count = 0;
   list_scoreboard book = new();

   positional_list_engine uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) book.check_response(rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic issue_request(input logic [FUNC_W-1:0] func, input logic [POS_W-1:0] pos,
                                input logic [ITEM_W-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {1'b0, value, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_request(func, pos, value);
   endtask

   task automatic directed_requests();
      issue_request(FN_REM_FRONT, 7'd0, 32'h0000_0000);
      issue_request(FN_REM_BACK, 7'd0, 32'hFFFF_FFFF);
      issue_request(FN_REM_AT, 7'd0, 32'h0000_0000);
      issue_request(FN_INS_AT, 7'd1, 32'h1111_1111);
      issue_request(FN_INS_AT, 7'd127, 32'h2222_2222);
      issue_request(FN_SPARE_A, 7'd127, 32'hFFFF_FFFF);
      issue_request(FN_SPARE_B, 7'd0, 32'h0000_0000);
      issue_request(FN_INS_FRONT, 7'd127, 32'h0000_0000);
      issue_request(FN_INS_BACK, 7'd64, 32'hFFFF_FFFF);
      issue_request(FN_INS_AT, 7'd1, 32'h1234_5678);
      issue_request(FN_INS_AT, 7'd3, 32'hA5A5_A5A5);
      issue_request(FN_INS_AT, 7'd0, 32'h5A5A_5A5A);
      issue_request(FN_REM_AT, 7'd5, 32'hFFFF_FFFF);
      issue_request(FN_REM_AT, 7'd127, 32'h0000_0000);
      issue_request(FN_REM_AT, 7'd2, 32'hFFFF_FFFF);
      issue_request(FN_REM_BACK, 7'd127, 32'h0000_0000);
      issue_request(FN_REM_FRONT, 7'd64, 32'hFFFF_FFFF);
      issue_request(FN_INS_FRONT, 7'd0, 32'h8000_0000);
      issue_request(FN_REM_AT, 7'd0, 32'h0000_0000);
      issue_request(FN_REM_BACK, 7'd0, 32'h0000_0000);
      issue_request(FN_REM_FRONT, 7'd0, 32'h0000_0000);
      issue_request(FN_REM_BACK, 7'd0, 32'h0000_0000);
   endtask

   // The list alternates between growing and shrinking so that it is driven
   // full and empty several times, with the occasional change of direction
   // in between.
   task automatic random_requests(input int count, inout logic growing);
      logic [FUNC_W-1:0] func;
      logic [POS_W-1:0]  pos;
      int                roll;
      int                n;
      for (n = 0; n < count; n++) begin
         if (book.fill >= LIST_DEPTH && $urandom_range(3) == 0) growing = 1'b0;
         if (book.fill == 0 && $urandom_range(3) == 0) growing = 1'b1;
         if ($urandom_range(40) == 0) growing = !growing;
         roll = $urandom_range(99);
         if (roll < 2) func = $urandom_range(1) ? FN_SPARE_A : FN_SPARE_B;
         else if (growing ? (roll < 75) : (roll >= 75)) func = FUNC_W'($urandom_range(2));
         else func = FUNC_W'($urandom_range(5, 3));
         roll = $urandom_range(99);
         if (roll < 85) pos = POS_W'($urandom_range(book.fill));
         else if (roll < 95) pos = POS_W'($urandom_range(127));
         else pos = POS_W'(book.fill + 1);
         issue_request(func, pos, $urandom());
      end
   endtask

   initial begin
      logic growing;
      growing = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      directed_requests();
      random_requests(PHASE_ITEMS, growing);

      sender_idle_pct = 83;
      receiver_stall_pct = 0;
      random_requests(PHASE_ITEMS, growing);

      sender_idle_pct = 0;
      receiver_stall_pct = 83;
      random_requests(PHASE_ITEMS, growing);

      sender_idle_pct = 20;
      receiver_stall_pct = 20;
      random_requests(PHASE_ITEMS, growing);

      req_tvalid <= 1'b0;
      while (book.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.errors == 0 && book.expected_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
